@@ design/rrsp_pkg.sv @@
// Shared types, constants and helper functions for the rounded-rect spotlight pipe.
// Used by every module of the block; depends on nothing.
package rrsp_pkg;

  localparam int EXP_ENTRIES = 256;
  localparam int EXP_IDX_W   = $clog2(EXP_ENTRIES);
  localparam int MAX_BOX     = 2000;
  localparam int CFG_ADDR_W  = 5;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int SQRT_STAGES = 8;
  localparam int DIV_STAGES  = 4;
  localparam logic [63:0] EXP_STEP_Q32 = 64'd4034748382;
  localparam logic [15:0] RECIP_255    = 16'h8081;
  localparam logic [16:0] SAT_Q        = 17'd65280;

  typedef enum logic [2:0] {
    REG_GLOW_COLOR  = 3'd0,
    REG_MAX_GLOW    = 3'd1,
    REG_MAX_BORDER  = 3'd2,
    REG_BORDER_THK  = 3'd3,
    REG_SPOT_SPREAD = 3'd4,
    REG_CORNER_RAD  = 3'd5
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0] glow_color;
    logic [7:0]  max_glow;
    logic [7:0]  max_border;
    logic [7:0]  border_thk;
    logic [15:0] spot_spread;
    logic [7:0]  corner_radius;
  } cfg_t;

  // one classified pixel waiting in the queue
  typedef struct packed {
    logic               invalid;
    logic [11:0]        dx;
    logic [11:0]        dy;
    logic signed [13:0] ex;
    logic signed [13:0] ey;
    logic [11:0]        op;
  } work_t;

  typedef struct packed {
    logic        invalid;
    logic [11:0] op;
    logic [31:0] sv;
    logic [31:0] sres;
    logic [31:0] rem;
    logic [16:0] dden;
    logic [7:0]  q;
    logic        over;
  } bk_t;

  typedef struct packed {
    logic [31:0] v;
    logic [31:0] res;
  } sq_t;

  typedef logic [16:0] exp_tbl_t [EXP_ENTRIES];

  function automatic exp_tbl_t build_exp_tbl();
    exp_tbl_t    t;
    logic [63:0] q;
    logic [63:0] r;
    q = 64'd1 << 32;
    for (int k = 0; k < EXP_ENTRIES; k++) begin
      r    = (q + 64'h8000) >> 16;
      t[k] = r[16:0];
      q    = (q * EXP_STEP_Q32 + 64'h8000_0000) >> 32;
    end
    return t;
  endfunction

  localparam exp_tbl_t EXP_TBL = build_exp_tbl();

  function automatic sq_t sqrt_step(sq_t s, logic [31:0] bitv);
    sq_t o;
    if (s.v >= s.res + bitv) begin
      o.v   = s.v - (s.res + bitv);
      o.res = (s.res >> 1) + bitv;
    end else begin
      o.v   = s.v;
      o.res = s.res >> 1;
    end
    return o;
  endfunction

  // restoring divide step for quotient bit b; result is {qbit, rem}
  function automatic logic [32:0] div_step(logic [31:0] rem, logic [16:0] dden, int b);
    logic [31:0] sh;
    sh = {15'd0, dden} << b;
    if (rem >= sh) return {1'b1, rem - sh};
    else return {1'b0, rem};
  endfunction

  // floor(x / 255) for x below 2^16
  function automatic logic [15:0] div255(logic [15:0] x);
    logic [31:0] p;
    p = {16'd0, x} * {16'd0, RECIP_255};
    return {7'd0, p[31:23]};
  endfunction

endpackage

@@ design/rrsp_front.sv @@
// Front end: takes a pixel, checks the box, and forms corner and cursor offsets.
// Uses rrsp_pkg types; feeds rrsp_fifo.
module rrsp_front (
  input  rrsp_pkg::cfg_t  cfg,
  input  logic [10:0]     pixel_x,
  input  logic [10:0]     pixel_y,
  input  logic [10:0]     box_width,
  input  logic [10:0]     box_height,
  input  logic [12:0]     cursor_x,
  input  logic [12:0]     cursor_y,
  input  logic [11:0]     master_opacity,
  output rrsp_pkg::work_t item
);

  logic signed [13:0] r_s;
  logic signed [13:0] ax, bx, ay, by;
  logic signed [13:0] mx, my;

  always_comb begin
    r_s = $signed({6'd0, cfg.corner_radius});
    ax  = r_s - $signed({3'd0, pixel_x});
    bx  = $signed({3'd0, pixel_x}) - $signed({3'd0, box_width}) + r_s;
    ay  = r_s - $signed({3'd0, pixel_y});
    by  = $signed({3'd0, pixel_y}) - $signed({3'd0, box_height}) + r_s;
    mx  = (ax > bx) ? ax : bx;
    my  = (ay > by) ? ay : by;

    item.invalid = (box_width == 11'd0) || (box_height == 11'd0) ||
                   (box_width > 11'(rrsp_pkg::MAX_BOX)) ||
                   (box_height > 11'(rrsp_pkg::MAX_BOX));
    item.dx = (mx > 14'sd0) ? mx[11:0] : 12'd0;
    item.dy = (my > 14'sd0) ? my[11:0] : 12'd0;
    item.ex = $signed({3'd0, pixel_x}) - $signed({cursor_x[12], cursor_x});
    item.ey = $signed({3'd0, pixel_y}) - $signed({cursor_y[12], cursor_y});
    item.op = master_opacity;
  end

endmodule

@@ design/rrsp_fifo.sv @@
// Short queue between front end and back end.
// Uses rrsp_pkg::work_t and the queue depth constants.
module rrsp_fifo (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  rrsp_pkg::work_t push_data,
  output logic            full,
  input  logic            pop,
  output rrsp_pkg::work_t pop_data,
  output logic            empty
);

  rrsp_pkg::work_t                   mem [rrsp_pkg::QUEUE_DEPTH];
  logic [rrsp_pkg::QPTR_W-1:0]       wr_ptr, rd_ptr;
  logic [rrsp_pkg::QCNT_W-1:0]       count;

  assign full     = (count == rrsp_pkg::QCNT_W'(rrsp_pkg::QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop) rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) count <= count + 1'b1;
      else if (pop && !push) count <= count - 1'b1;
    end
  end

endmodule

@@ design/rrsp_back.sv @@
// Back end: squares, pipelined root and exponent divide, table, alpha and color.
// Uses rrsp_pkg types, table and step functions; fed by rrsp_fifo.
module rrsp_back (
  input  logic            clk,
  input  logic            rst,
  input  rrsp_pkg::cfg_t  cfg,
  input  logic            in_valid,
  input  rrsp_pkg::work_t in_item,
  output logic            done,
  output logic [7:0]      alpha,
  output logic [7:0]      red,
  output logic [7:0]      green,
  output logic [7:0]      blue
);

  logic            sv [rrsp_pkg::SQRT_STAGES+1];
  rrsp_pkg::bk_t   stg [rrsp_pkg::SQRT_STAGES+1];

  // stage 0: squares and divide operands
  logic [12:0] aex, aey;
  logic [23:0] sqd;
  logic [26:0] sq;
  logic [31:0] num;

  always_comb begin
    aex = in_item.ex[13] ? 13'(-in_item.ex) : in_item.ex[12:0];
    aey = in_item.ey[13] ? 13'(-in_item.ey) : in_item.ey[12:0];
    sqd = 24'({12'd0, in_item.dx} * {12'd0, in_item.dx}) +
          24'({12'd0, in_item.dy} * {12'd0, in_item.dy});
    sq  = 27'({13'd0, aex} * {13'd0, aex}) + 27'({13'd0, aey} * {13'd0, aey});
    num = {sq, 5'd0} + {16'd0, cfg.spot_spread};
  end

  always_ff @(posedge clk) begin
    if (rst) sv[0] <= 1'b0;
    else sv[0] <= in_valid;
  end

  always_ff @(posedge clk) begin
    stg[0].invalid <= in_item.invalid;
    stg[0].op      <= in_item.op;
    stg[0].sv      <= {sqd, 8'd0};
    stg[0].sres    <= '0;
    stg[0].rem     <= num;
    stg[0].dden    <= (cfg.spot_spread == 16'd0) ? 17'd2 : {cfg.spot_spread, 1'b0};
    stg[0].q       <= '0;
    stg[0].over    <= 1'b0;
  end

  // two root steps per stage, two quotient bits per stage in the first four
  for (genvar k = 1; k <= rrsp_pkg::SQRT_STAGES; k++) begin : g_root
    localparam int I0 = 2 * (k - 1);
    localparam int QB = (k <= rrsp_pkg::DIV_STAGES) ? 7 - I0 : 1;
    rrsp_pkg::sq_t  s0, s1, s2;
    rrsp_pkg::bk_t  nx;
    logic [32:0]    d0, d1;

    always_comb begin
      nx      = stg[k-1];
      s0.v    = stg[k-1].sv;
      s0.res  = stg[k-1].sres;
      s1      = rrsp_pkg::sqrt_step(s0, 32'd1 << (30 - 2 * I0));
      s2      = rrsp_pkg::sqrt_step(s1, 32'd1 << (28 - 2 * I0));
      nx.sv   = s2.v;
      nx.sres = s2.res;
      d0      = '0;
      d1      = '0;
      if (k == 1) nx.over = (stg[0].rem >= {7'd0, stg[0].dden, 8'd0});
      if (k <= rrsp_pkg::DIV_STAGES) begin
        d0     = rrsp_pkg::div_step(stg[k-1].rem, stg[k-1].dden, QB);
        d1     = rrsp_pkg::div_step(d0[31:0], stg[k-1].dden, QB - 1);
        nx.rem = d1[31:0];
        nx.q[QB]   = d0[32];
        nx.q[QB-1] = d1[32];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) sv[k] <= 1'b0;
      else sv[k] <= sv[k-1];
    end

    always_ff @(posedge clk) begin
      stg[k] <= nx;
    end
  end

  // tail stages
  localparam int LAST = rrsp_pkg::SQRT_STAGES;
  logic [6:0]  tv;
  logic [15:0] d16;
  logic [20:0] lhs, rhs;
  logic [11:0] r16;
  logic [15:0] diff;

  logic        t1_inv, t1_hit;
  logic [16:0] t1_e;
  logic [4:0]  t1_mask, t2_mask, t3_mask;
  logic [11:0] t1_op, t2_op;
  logic        t2_inv, t3_inv, t4_inv;
  logic [23:0] t2_v;
  logic [35:0] t3_p;
  logic [16:0] t4_q;
  logic [7:0]  t5_a, t6_a;
  logic [15:0] t6_r, t6_g, t6_b;

  logic [24:0] glow;
  logic [23:0] bval;
  logic [40:0] pm;
  logic [15:0] a16;

  always_comb begin
    d16  = (stg[LAST].sres[31:16] != 16'd0) ? 16'hFFFF : stg[LAST].sres[15:0];
    r16  = {cfg.corner_radius, 4'd0};
    lhs  = 21'({5'd0, d16} * 21'd10) + {9'd0, cfg.border_thk, 4'd0};
    rhs  = 21'({13'd0, cfg.corner_radius} * 21'd160);
    diff = d16 - {4'd0, r16};
    glow = 25'({17'd0, cfg.max_glow} * {8'd0, t1_e});
    bval = t1_hit ? {cfg.max_border, 16'd0} : 24'd0;
    pm   = {5'd0, t3_p} * {36'd0, t3_mask};
    a16  = rrsp_pkg::div255(t4_q[15:0]);
  end

  always_ff @(posedge clk) begin
    if (rst) tv <= '0;
    else tv <= {tv[5:0], sv[LAST]};
  end

  always_ff @(posedge clk) begin
    // table, border band and edge mask
    t1_inv <= stg[LAST].invalid;
    t1_op  <= stg[LAST].op;
    t1_e   <= stg[LAST].over ? 17'd0 : rrsp_pkg::EXP_TBL[stg[LAST].q];
    t1_hit <= (lhs >= rhs) && (d16 <= {4'd0, r16});
    if (d16 <= {4'd0, r16}) t1_mask <= 5'd16;
    else if (diff >= 16'd16) t1_mask <= 5'd0;
    else t1_mask <= 5'd16 - diff[4:0];
    // spotlight against border
    t2_inv  <= t1_inv;
    t2_op   <= t1_op;
    t2_mask <= t1_mask;
    t2_v    <= (glow > {1'b0, bval}) ? glow[23:0] : bval;
    // opacity
    t3_inv  <= t2_inv;
    t3_mask <= t2_mask;
    t3_p    <= {12'd0, t2_v} * {24'd0, t2_op};
    // mask, drop the 2^24 scale
    t4_inv <= t3_inv;
    t4_q   <= pm[40:24];
    // divide by 255 and clamp
    if (t4_inv) t5_a <= 8'd0;
    else if (t4_q >= rrsp_pkg::SAT_Q) t5_a <= 8'd255;
    else t5_a <= a16[7:0];
    // premultiply
    t6_a <= t5_a;
    t6_r <= {8'd0, t5_a} * {8'd0, cfg.glow_color[7:0]};
    t6_g <= {8'd0, t5_a} * {8'd0, cfg.glow_color[15:8]};
    t6_b <= {8'd0, t5_a} * {8'd0, cfg.glow_color[23:16]};
    alpha <= t6_a;
    red   <= 8'(rrsp_pkg::div255(t6_r));
    green <= 8'(rrsp_pkg::div255(t6_g));
    blue  <= 8'(rrsp_pkg::div255(t6_b));
  end

  assign done = tv[6];

endmodule

@@ design/rounded_rect_spotlight_pixel.sv @@
// Rounded-rect spotlight pixel: one pixel per clock, result strobed by done.
// done rises after the queue, the operand stage, the 8-stage square root (two
// root steps per stage) and the 7-stage alpha and color tail. Throughput is
// one pixel per cycle; busy rises only if the queue fills. Synchronous reset
// clears the pipe and queue and loads register defaults. Top level; uses
// rrsp_pkg, rrsp_front, rrsp_fifo, rrsp_back.
module rounded_rect_spotlight_pixel (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [10:0]                   pixel_x,
  input  logic [10:0]                   pixel_y,
  input  logic [10:0]                   box_width,
  input  logic [10:0]                   box_height,
  input  logic [12:0]                   cursor_x,
  input  logic [12:0]                   cursor_y,
  input  logic [11:0]                   master_opacity,
  output logic                          done,
  output logic [7:0]                    alpha,
  output logic [7:0]                    red,
  output logic [7:0]                    green,
  output logic [7:0]                    blue,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rrsp_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  rrsp_pkg::cfg_t   cfg;
  rrsp_pkg::work_t  item, q_item;
  rrsp_pkg::cfg_reg_t ridx;
  logic             q_full, q_empty, push;

  assign pready = 1'b1;
  assign ridx   = rrsp_pkg::cfg_reg_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.glow_color    <= 24'hFFFFFF;
      cfg.max_glow      <= 8'd120;
      cfg.max_border    <= 8'd255;
      cfg.border_thk    <= 8'd15;
      cfg.spot_spread   <= 16'd350;
      cfg.corner_radius <= 8'd6;
    end else if (psel && penable && pwrite) begin
      unique case (ridx)
        rrsp_pkg::REG_GLOW_COLOR:  cfg.glow_color    <= pwdata[23:0];
        rrsp_pkg::REG_MAX_GLOW:    cfg.max_glow      <= pwdata[7:0];
        rrsp_pkg::REG_MAX_BORDER:  cfg.max_border    <= pwdata[7:0];
        rrsp_pkg::REG_BORDER_THK:  cfg.border_thk    <= pwdata[7:0];
        rrsp_pkg::REG_SPOT_SPREAD: cfg.spot_spread   <= pwdata[15:0];
        rrsp_pkg::REG_CORNER_RAD:  cfg.corner_radius <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (ridx)
      rrsp_pkg::REG_GLOW_COLOR:  prdata = {8'd0, cfg.glow_color};
      rrsp_pkg::REG_MAX_GLOW:    prdata = {24'd0, cfg.max_glow};
      rrsp_pkg::REG_MAX_BORDER:  prdata = {24'd0, cfg.max_border};
      rrsp_pkg::REG_BORDER_THK:  prdata = {24'd0, cfg.border_thk};
      rrsp_pkg::REG_SPOT_SPREAD: prdata = {16'd0, cfg.spot_spread};
      rrsp_pkg::REG_CORNER_RAD:  prdata = {24'd0, cfg.corner_radius};
      default:                   prdata = 32'd0;
    endcase
  end

  assign busy = q_full;
  assign push = start && !q_full;

  rrsp_front u_front (
    .cfg            (cfg),
    .pixel_x        (pixel_x),
    .pixel_y        (pixel_y),
    .box_width      (box_width),
    .box_height     (box_height),
    .cursor_x       (cursor_x),
    .cursor_y       (cursor_y),
    .master_opacity (master_opacity),
    .item           (item)
  );

  rrsp_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (item),
    .full      (q_full),
    .pop       (!q_empty),
    .pop_data  (q_item),
    .empty     (q_empty)
  );

  rrsp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .in_valid (!q_empty),
    .in_item  (q_item),
    .done     (done),
    .alpha    (alpha),
    .red      (red),
    .green    (green),
    .blue     (blue)
  );

endmodule

@@ dv/rounded_rect_spotlight_pixel_tb.sv @@
// Testbench for the rounded-rect spotlight pixel block: drives pixel words, writes
// registers over APB, and checks every result against an in-bench predictor.
// Depends on rrsp_pkg and the rounded_rect_spotlight_pixel RTL.
module rounded_rect_spotlight_pixel_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT  = 5000;
  localparam int TAIL_CYCLES = 40;
  localparam int PHASE_ITEMS = 250;
  localparam int UNUSED_REG  = 6;

  typedef struct {
    logic [10:0]        px;
    logic [10:0]        py;
    logic [10:0]        bw;
    logic [10:0]        bh;
    logic signed [12:0] cx;
    logic signed [12:0] cy;
    logic [11:0]        op;
  } pix_t;

  typedef struct {
    logic [7:0] alpha;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } shade_t;

  class spotlight_scoreboard;
    longint exp_lut [rrsp_pkg::EXP_ENTRIES];
    logic [23:0] glow_color;
    logic [7:0]  max_glow, max_border, thick, corner_r;
    logic [15:0] spread;
    shade_t      pending_q [$];
    int          errors;

    function new();
      logic [63:0] q;
      q = 64'd1 << 32;
      for (int k = 0; k < rrsp_pkg::EXP_ENTRIES; k++) begin
        exp_lut[k] = longint'((q + 64'h8000) >> 16);
        q = (q * 64'd4034748382 + 64'h8000_0000) >> 32;
      end
      glow_color = 24'hFFFFFF;
      max_glow   = 120;
      max_border = 255;
      thick      = 15;
      spread     = 350;
      corner_r   = 6;
      errors     = 0;
    endfunction

    function void set_reg(int idx, logic [31:0] val);
      case (idx)
        rrsp_pkg::REG_GLOW_COLOR:  glow_color = val[23:0];
        rrsp_pkg::REG_MAX_GLOW:    max_glow   = val[7:0];
        rrsp_pkg::REG_MAX_BORDER:  max_border = val[7:0];
        rrsp_pkg::REG_BORDER_THK:  thick      = val[7:0];
        rrsp_pkg::REG_SPOT_SPREAD: spread     = val[15:0];
        rrsp_pkg::REG_CORNER_RAD:  corner_r   = val[7:0];
        default: ;
      endcase
    endfunction

    function longint root_q4(longint v);
      longint res, bitv;
      res  = 0;
      bitv = longint'(1) << 46;
      for (int i = 0; i < 24; i++) begin
        if (v >= res + bitv) begin
          v   = v - (res + bitv);
          res = (res >> 1) + bitv;
        end else begin
          res = res >> 1;
        end
        bitv = bitv >> 2;
      end
      return res;
    endfunction

    function longint corner_off(longint p, longint size, longint r);
      longint a, b, m;
      a = r - p;
      b = p - (size - r);
      m = (a > b) ? a : b;
      return (m > 0) ? m : 0;
    endfunction

    function void note(pix_t p);
      longint x, y, w, h, cx, cy, r, dx, dy, d16, ex, ey, sq, spr, idx;
      longint glow, border, mask, v, a;
      shade_t o;
      x = p.px; y = p.py; w = p.bw; h = p.bh;
      cx = p.cx; cy = p.cy;
      r = corner_r;
      if (w == 0 || h == 0 || w > rrsp_pkg::MAX_BOX || h > rrsp_pkg::MAX_BOX) begin
        o = '{8'd0, 8'd0, 8'd0, 8'd0};
      end else begin
        dx  = corner_off(x, w, r);
        dy  = corner_off(y, h, r);
        d16 = root_q4((dx * dx + dy * dy) * 256);
        if (d16 > 65535) d16 = 65535;
        ex  = x - cx;
        ey  = y - cy;
        sq  = ex * ex + ey * ey;
        spr = (spread == 0) ? 1 : spread;
        idx = (sq * 32 + spr) / (2 * spr);
        glow = (idx < rrsp_pkg::EXP_ENTRIES) ? max_glow * exp_lut[idx] : 0;
        border = 0;
        if (10 * d16 + 16 * thick >= 160 * r && d16 <= 16 * r)
          border = longint'(max_border) << 16;
        if (d16 <= 16 * r) mask = 16;
        else if (d16 - 16 * r >= 16) mask = 0;
        else mask = 16 - (d16 - 16 * r);
        v = (glow > border) ? glow : border;
        a = (v * p.op * mask) / (longint'(255) << 24);
        if (a > 255) a = 255;
        o.alpha = a;
        o.red   = (a * glow_color[7:0]) / 255;
        o.green = (a * glow_color[15:8]) / 255;
        o.blue  = (a * glow_color[23:16]) / 255;
      end
      pending_q.push_back(o);
    endfunction

    task report(string what, longint got, longint want);
      $display("mismatch %s: got %0d want %0d", what, got, want);
      errors++;
    endtask

    task check(shade_t got);
      shade_t want;
      if (pending_q.size() == 0) begin
        report("unexpected word alpha", got.alpha, -1);
        return;
      end
      want = pending_q.pop_front();
      if (got.alpha !== want.alpha) report("alpha", got.alpha, want.alpha);
      if (got.red !== want.red)     report("red", got.red, want.red);
      if (got.green !== want.green) report("green", got.green, want.green);
      if (got.blue !== want.blue)   report("blue", got.blue, want.blue);
    endtask
  endclass

  logic clk, rst, start, busy, done;
  logic [7:0] alpha, red, green, blue;
  logic psel, penable, pwrite, pready;
  logic [rrsp_pkg::CFG_ADDR_W-1:0] paddr;
  logic [31:0] pwdata, prdata;
  pix_t cur;
  spotlight_scoreboard sb;
  int idle_pct;
  int quiet;

  rounded_rect_spotlight_pixel dut (
    .clk, .rst, .start, .busy,
    .pixel_x(cur.px), .pixel_y(cur.py), .box_width(cur.bw), .box_height(cur.bh),
    .cursor_x(cur.cx), .cursor_y(cur.cy), .master_opacity(cur.op),
    .done, .alpha, .red, .green, .blue,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // pre-edge values are seen here since the block updates with nonblocking writes
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) sb.note(cur);
      if (done) sb.check('{alpha, red, green, blue});
    end
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      quiet <= 0;
    end else if (quiet >= IDLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  // idle each cycle with the current percentage, then hold the word until taken
  task automatic send_pixel(pix_t p);
    @(negedge clk);
    while ($urandom_range(0, 99) < idle_pct) begin
      start = 1'b0;
      @(negedge clk);
    end
    cur   = p;
    start = 1'b1;
    do @(posedge clk); while (busy);
  endtask

  task automatic drain();
    @(negedge clk);
    start = 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(int idx, logic [31:0] val);
    @(negedge clk);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = rrsp_pkg::CFG_ADDR_W'(4 * idx);
    pwdata  = val;
    @(negedge clk);
    penable = 1'b1;
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    sb.set_reg(idx, val);
  endtask

  function automatic pix_t make_pixel(logic [10:0] px, logic [10:0] py, logic [10:0] bw,
                                      logic [10:0] bh, int cx, int cy, logic [11:0] op);
    pix_t p;
    p.px = px; p.py = py; p.bw = bw; p.bh = bh;
    p.cx = 13'(cx); p.cy = 13'(cy); p.op = op;
    return p;
  endfunction

  function automatic int pick_dim();
    int roll, r;
    roll = $urandom_range(0, 99);
    r    = sb.corner_r;
    if (roll < 8) begin
      return ($urandom_range(0, 1) != 0) ? 0 :
             $urandom_range(rrsp_pkg::MAX_BOX + 1, 2047);
    end
    if (roll < 15) return $urandom_range(1, rrsp_pkg::MAX_BOX);
    return (2 * r + 48 > rrsp_pkg::MAX_BOX) ? $urandom_range(1, rrsp_pkg::MAX_BOX) :
                                             $urandom_range(1, 2 * r + 48);
  endfunction

  function automatic int pick_pos(int size);
    int hi;
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 2047);
    hi = (size + 3 > 2047) ? 2047 : size + 3;
    return $urandom_range(0, hi);
  endfunction

  function automatic int pick_cursor(int pos);
    if ($urandom_range(0, 99) < 15) return $urandom_range(0, 6143) - 2048;
    return pos + $urandom_range(0, 120) - 60;
  endfunction

  function automatic pix_t random_pixel();
    pix_t p;
    int w, h, x, y;
    w = pick_dim();
    h = pick_dim();
    x = pick_pos(w);
    y = pick_pos(h);
    p = make_pixel(11'(x), 11'(y), 11'(w), 11'(h), pick_cursor(x), pick_cursor(y), 12'd0);
    p.op = ($urandom_range(0, 9) == 0) ? 12'hFFF : 12'($urandom_range(0, 4095));
    return p;
  endfunction

  task automatic directed_pixels();
    send_pixel(make_pixel(0, 0, 20, 20, 0, 0, 12'hFFF));
    send_pixel(make_pixel(10, 10, 20, 20, 10, 10, 12'hFFF));
    send_pixel(make_pixel(10, 10, 20, 20, 10, 10, 12'h000));
    send_pixel(make_pixel(5, 0, 20, 20, 5, 2, 12'h800));
    send_pixel(make_pixel(19, 19, 20, 20, -2048, -2048, 12'hFFF));
    send_pixel(make_pixel(19, 19, 20, 20, 4095, 4095, 12'hFFF));
    // invalid boxes: zero and oversized sides, then the largest valid box
    send_pixel(make_pixel(3, 3, 0, 20, 3, 3, 12'hFFF));
    send_pixel(make_pixel(3, 3, 20, 0, 3, 3, 12'hFFF));
    send_pixel(make_pixel(3, 3, rrsp_pkg::MAX_BOX + 1, 20, 3, 3, 12'hFFF));
    send_pixel(make_pixel(3, 3, 20, 2047, 3, 3, 12'hFFF));
    send_pixel(make_pixel(3, 3, rrsp_pkg::MAX_BOX, rrsp_pkg::MAX_BOX, 3, 3, 12'hFFF));
    send_pixel(make_pixel(1999, 1999, rrsp_pkg::MAX_BOX, rrsp_pkg::MAX_BOX,
                          1999, 1999, 12'hFFF));
    // pixels past the box edge, including the far corner of the field, and a one-pixel box
    send_pixel(make_pixel(21, 10, 20, 20, 21, 10, 12'hFFF));
    send_pixel(make_pixel(2047, 2047, 20, 20, 2047, 2047, 12'hFFF));
    send_pixel(make_pixel(0, 2047, 1, 1, 0, 0, 12'hFFF));
    send_pixel(make_pixel(0, 0, 1, 1, 0, 0, 12'hFFF));
    // spotlight exponent beyond the table, then cursors on the pixel
    send_pixel(make_pixel(6, 6, 40, 40, 400, 400, 12'hFFF));
    send_pixel(make_pixel(2, 1, 40, 40, 60, 60, 12'h7FF));
    send_pixel(make_pixel(0, 1, 12, 12, 0, 1, 12'hFFF));
    send_pixel(make_pixel(1, 0, 12, 12, 1, 0, 12'hFFF));
  endtask

  task automatic load_setting(int ph);
    case (ph)
      1: begin
        write_reg(rrsp_pkg::REG_GLOW_COLOR, 32'hFF00_0000);
        write_reg(rrsp_pkg::REG_MAX_GLOW, 32'hFFFF_FFFF);
        write_reg(rrsp_pkg::REG_MAX_BORDER, 32'h0000_0000);
        write_reg(rrsp_pkg::REG_BORDER_THK, 32'h0000_0000);
        write_reg(rrsp_pkg::REG_SPOT_SPREAD, 32'hFFFF_0000);
        write_reg(rrsp_pkg::REG_CORNER_RAD, 32'h0000_0000);
      end
      2: begin
        write_reg(rrsp_pkg::REG_GLOW_COLOR, 32'h00FF_FFFF);
        write_reg(rrsp_pkg::REG_MAX_GLOW, 32'h0000_0000);
        write_reg(rrsp_pkg::REG_MAX_BORDER, 32'h0000_00FF);
        write_reg(rrsp_pkg::REG_BORDER_THK, 32'h0000_00FF);
        write_reg(rrsp_pkg::REG_SPOT_SPREAD, 32'h0000_FFFF);
        write_reg(rrsp_pkg::REG_CORNER_RAD, 32'h0000_00FF);
      end
      default: begin
        write_reg(rrsp_pkg::REG_GLOW_COLOR, $urandom);
        write_reg(rrsp_pkg::REG_MAX_GLOW, $urandom);
        write_reg(rrsp_pkg::REG_MAX_BORDER, $urandom);
        write_reg(rrsp_pkg::REG_BORDER_THK, $urandom_range(0, 255));
        write_reg(rrsp_pkg::REG_SPOT_SPREAD,
                  ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(1, 3000));
        write_reg(rrsp_pkg::REG_CORNER_RAD, $urandom_range(0, 30));
        // an unmapped address must leave the registers alone
        write_reg(UNUSED_REG, $urandom);
      end
    endcase
  endtask

  initial begin
    sb       = new();
    rst      = 1'b1;
    start    = 1'b0;
    psel     = 1'b0;
    penable  = 1'b0;
    pwrite   = 1'b0;
    paddr    = '0;
    pwdata   = '0;
    quiet    = 0;
    idle_pct = 14;
    cur      = make_pixel(0, 0, 1, 1, 0, 0, 12'd0);
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_pixels();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph > 0) begin
        drain();
        load_setting(ph);
      end
      idle_pct = (ph < 2) ? 14 : (ph < 4) ? 72 : 0;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (ph == 0 && i == PHASE_ITEMS / 2) drain();
        send_pixel(random_pixel());
      end
    end
    drain();

    if (sb.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
